// ----- src/dlsq_pkg.sv -----
package dlsq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned ID_BITS     = 8;
  localparam int unsigned PID_W       = 8;
  localparam int unsigned DELTA_W     = 32;
  localparam int unsigned KIND_W      = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_FULL   = 2'd1,
    KIND_WOKEN  = 2'd2,
    KIND_IDLE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_REPLY,
    ST_DECR,
    ST_POP
  } state_e;

  typedef struct packed {
    logic shift;
    logic dec;
  } cell_ctrl_t;

endpackage

// ----- src/dlsq_if.sv -----
interface dlsq_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [dlsq_pkg::PID_W-1:0]   process_id;
  logic [dlsq_pkg::DELTA_W-1:0] delay_ticks;

  modport source (output valid, func, process_id, delay_ticks, input ready);
  modport sink   (input valid, func, process_id, delay_ticks, output ready);
endinterface

interface dlsq_out_if;
  logic                       valid;
  logic                       ready;
  logic [dlsq_pkg::KIND_W-1:0] kind;
  logic [dlsq_pkg::PID_W-1:0]  woken_id;
  logic                       last;

  modport source (output valid, kind, woken_id, last, input ready);
  modport sink   (input valid, kind, woken_id, last, output ready);
endinterface

// ----- src/dlsq_cell.sv -----
module dlsq_cell #(
  parameter int unsigned IdBits = dlsq_pkg::ID_BITS
) (
  input  logic                         clk_i,
  input  dlsq_pkg::cell_ctrl_t         ctrl_i,
  input  logic [IdBits-1:0]            id_i,
  input  logic [dlsq_pkg::DELTA_W-1:0] delta_i,
  output logic [IdBits-1:0]            id_o,
  output logic [dlsq_pkg::DELTA_W-1:0] delta_o
);
  import dlsq_pkg::*;

  logic [IdBits-1:0]  id_q, id_d;
  logic [DELTA_W-1:0] delta_q, delta_d;

  always_comb begin
    id_d    = id_q;
    delta_d = delta_q;
    if (ctrl_i.shift) begin
      id_d    = id_i;
      delta_d = delta_i;
    end else if (ctrl_i.dec && (delta_q != '0)) begin
      delta_d = delta_q - DELTA_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    id_q    <= id_d;
    delta_q <= delta_d;
  end

  assign id_o    = id_q;
  assign delta_o = delta_q;

endmodule

// ----- src/delta_list_sleep_queue.sv -----
// Bounded delta-list sleep queue built as a ring of cells, each holding one
// process id and its delta. An insert rotates the whole ring once past a
// compare unit at the head, then posts its reply, and only then can the next
// request be taken. A tick first decrements the head delta, then pops each
// woken process by shifting the ring one place, then the next request can be
// taken. An insert into a full queue and a tick on an empty queue go straight
// to posting their reply; a tick that wakes nobody posts its reply after the
// decrement. Posting a reply or a wake waits while the output register is
// full. The output register lets a finished result wait while the queue
// works on.
module delta_list_sleep_queue #(
  parameter int unsigned QueueDepth = dlsq_pkg::QUEUE_DEPTH,
  parameter int unsigned IdBits     = dlsq_pkg::ID_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dlsq_in_if.sink     req_i,
  dlsq_out_if.source  rsp_o
);
  import dlsq_pkg::*;

  localparam int unsigned CntW  = $clog2(QueueDepth + 1);
  localparam int unsigned StepW = $clog2(QueueDepth);

  state_e state_q, state_d;

  logic [CntW-1:0]    count_q, count_d;
  logic [StepW-1:0]   step_q, step_d;
  logic [DELTA_W-1:0] total_q, total_d;
  logic [DELTA_W-1:0] cum_q, cum_d;
  logic [IdBits-1:0]  new_id_q, new_id_d;
  logic               inserted_q, inserted_d;
  logic [IdBits-1:0]  carry_id_q, carry_id_d;
  logic [DELTA_W-1:0] carry_delta_q, carry_delta_d;
  kind_e              reply_kind_q, reply_kind_d;

  logic               out_valid_q, out_valid_d;
  kind_e              out_kind_q, out_kind_d;
  logic [PID_W-1:0]   out_id_q, out_id_d;
  logic               out_last_q, out_last_d;

  logic [IdBits-1:0]  id_w    [QueueDepth];
  logic [DELTA_W-1:0] delta_w [QueueDepth];
  logic [IdBits-1:0]  feed_id;
  logic [DELTA_W-1:0] feed_delta;

  logic       in_fire, slot_free, head_zero, pop_last, occupied, go_here;
  logic       load_woken, load_reply;
  logic [DELTA_W:0] sum;
  cell_ctrl_t head_ctrl, body_ctrl;

  assign in_fire   = req_i.valid && req_i.ready;
  assign slot_free = !out_valid_q || rsp_o.ready;
  assign head_zero = (delta_w[0] == '0);
  assign pop_last  = (count_q == CntW'(1)) || (delta_w[1] != '0);
  assign occupied  = ({1'b0, step_q} < (StepW + 1)'(count_q));
  assign sum       = {1'b0, cum_q} + {1'b0, delta_w[0]};
  assign go_here   = !occupied || (sum > {1'b0, total_q});

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    if (i == QueueDepth - 1) begin : g_tail
      dlsq_cell #(.IdBits(IdBits)) u_cell (
        .clk_i   (clk_i),
        .ctrl_i  (body_ctrl),
        .id_i    (feed_id),
        .delta_i (feed_delta),
        .id_o    (id_w[i]),
        .delta_o (delta_w[i])
      );
    end else begin : g_body
      dlsq_cell #(.IdBits(IdBits)) u_cell (
        .clk_i   (clk_i),
        .ctrl_i  ((i == 0) ? head_ctrl : body_ctrl),
        .id_i    (id_w[i+1]),
        .delta_i (delta_w[i+1]),
        .id_o    (id_w[i]),
        .delta_o (delta_w[i])
      );
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (!req_i.func) begin
            state_d = (count_q == CntW'(QueueDepth)) ? ST_REPLY : ST_INSERT;
          end else begin
            state_d = (count_q == '0) ? ST_REPLY : ST_DECR;
          end
        end
      end
      ST_INSERT: begin
        if (step_q == StepW'(QueueDepth - 1)) begin
          state_d = ST_REPLY;
        end
      end
      ST_REPLY: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_DECR: begin
        state_d = ST_POP;
      end
      ST_POP: begin
        if (!head_zero) begin
          state_d = ST_REPLY;
        end else if (slot_free && pop_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_i.ready     = (state_q == ST_IDLE);
    load_woken      = (state_q == ST_POP) && head_zero && slot_free;
    load_reply      = (state_q == ST_REPLY) && slot_free;
    body_ctrl.dec   = 1'b0;
    body_ctrl.shift = (state_q == ST_INSERT) || load_woken;
    head_ctrl.dec   = (state_q == ST_DECR);
    head_ctrl.shift = body_ctrl.shift;
  end

  always_comb begin
    count_d       = count_q;
    step_d        = step_q;
    total_d       = total_q;
    cum_d         = cum_q;
    new_id_d      = new_id_q;
    inserted_d    = inserted_q;
    carry_id_d    = carry_id_q;
    carry_delta_d = carry_delta_q;
    reply_kind_d  = reply_kind_q;
    feed_id       = id_w[0];
    feed_delta    = delta_w[0];

    if (in_fire) begin
      new_id_d   = IdBits'(req_i.process_id);
      total_d    = (req_i.delay_ticks == '0) ? DELTA_W'(1) : req_i.delay_ticks;
      cum_d      = '0;
      step_d     = '0;
      inserted_d = 1'b0;
      if (!req_i.func) begin
        reply_kind_d = KIND_FULL;
      end else begin
        reply_kind_d = KIND_IDLE;
      end
    end

    if (state_q == ST_INSERT) begin
      step_d = step_q + StepW'(1);
      if (inserted_q) begin
        feed_id       = carry_id_q;
        feed_delta    = carry_delta_q;
        carry_id_d    = id_w[0];
        carry_delta_d = delta_w[0];
      end else if (go_here) begin
        feed_id       = new_id_q;
        feed_delta    = total_q - cum_q;
        carry_id_d    = id_w[0];
        carry_delta_d = DELTA_W'(sum - {1'b0, total_q});
        inserted_d    = 1'b1;
      end else begin
        cum_d = sum[DELTA_W-1:0];
      end
      if (step_q == StepW'(QueueDepth - 1)) begin
        count_d      = count_q + CntW'(1);
        reply_kind_d = KIND_ACCEPT;
      end
    end

    if ((state_q == ST_POP) && !head_zero) begin
      reply_kind_d = KIND_IDLE;
    end

    if (load_woken) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_kind_d  = out_kind_q;
    out_id_d    = out_id_q;
    out_last_d  = out_last_q;
    if (load_woken) begin
      out_valid_d = 1'b1;
      out_kind_d  = KIND_WOKEN;
      out_id_d    = PID_W'(id_w[0]);
      out_last_d  = pop_last;
    end else if (load_reply) begin
      out_valid_d = 1'b1;
      out_kind_d  = reply_kind_q;
      out_id_d    = '0;
      out_last_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      inserted_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      inserted_q  <= inserted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q        <= step_d;
    total_q       <= total_d;
    cum_q         <= cum_d;
    new_id_q      <= new_id_d;
    carry_id_q    <= carry_id_d;
    carry_delta_q <= carry_delta_d;
    reply_kind_q  <= reply_kind_d;
    out_kind_q    <= out_kind_d;
    out_id_q      <= out_id_d;
    out_last_q    <= out_last_d;
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.kind     = out_kind_q;
  assign rsp_o.woken_id = out_id_q;
  assign rsp_o.last     = out_last_q;

endmodule

// ----- src/dlsq_checker.sv -----
module dlsq_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [dlsq_pkg::KIND_W-1:0] out_kind_i,
  input logic [dlsq_pkg::PID_W-1:0]  out_woken_id_i,
  input logic                        out_last_i
);
  import dlsq_pkg::*;

  // A result that waits must keep its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_kind_i) && $stable(out_woken_id_i) && $stable(out_last_i))
  else $error("stalled result changed");

  // Only a wake result can be followed by more results of the same request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i != KIND_WOKEN) |-> out_last_i)
  else $error("non-wake result not marked last");

  // Results other than wakes carry no process id.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i != KIND_WOKEN) |-> (out_woken_id_i == '0))
  else $error("non-wake result carries an id");

  // The queue works on one request at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
  else $error("request taken while busy");

endmodule

bind delta_list_sleep_queue dlsq_checker u_dlsq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (req_i.valid),
  .in_ready_i     (req_i.ready),
  .out_valid_i    (rsp_o.valid),
  .out_ready_i    (rsp_o.ready),
  .out_kind_i     (rsp_o.kind),
  .out_woken_id_i (rsp_o.woken_id),
  .out_last_i     (rsp_o.last)
);

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import dlsq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned STALL_CYCLES = 300;

  typedef struct packed {
    kind_e            kind;
    logic [PID_W-1:0] woken_id;
    logic             last;
  } wake_rsp_t;

  logic clk_i;
  logic rst_ni;

  dlsq_in_if  req_if ();
  dlsq_out_if rsp_if ();

  delta_list_sleep_queue u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  logic [PID_W-1:0]   sleep_pid   [QUEUE_DEPTH];
  logic [DELTA_W-1:0] sleep_delta [QUEUE_DEPTH];
  int unsigned        sleep_count;
  wake_rsp_t          pending_rsp [$];

  logic        quiet;
  int unsigned stall_request;
  int unsigned error_count;
  int unsigned cycle_count = 0;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic void push_rsp(input kind_e kind, input logic [PID_W-1:0] id,
                                   input logic last);
    wake_rsp_t r;
    r.kind     = kind;
    r.woken_id = id;
    r.last     = last;
    pending_rsp.push_back(r);
  endfunction

  function automatic void predict_insert(input logic [PID_W-1:0] pid,
                                         input logic [DELTA_W-1:0] dly);
    logic [DELTA_W:0] want;
    logic [DELTA_W:0] sum;
    int unsigned      pos;
    int unsigned      i;
    if (sleep_count >= QUEUE_DEPTH) begin
      push_rsp(KIND_FULL, '0, 1'b1);
    end else begin
      want = (dly == '0) ? (DELTA_W + 1)'(1) : {1'b0, dly};
      sum  = '0;
      pos  = 0;
      while (pos < sleep_count && sum + sleep_delta[pos] <= want) begin
        sum = sum + sleep_delta[pos];
        pos++;
      end
      for (i = sleep_count; i > pos; i--) begin
        sleep_pid[i]   = sleep_pid[i-1];
        sleep_delta[i] = sleep_delta[i-1];
      end
      sleep_pid[pos]   = pid & PID_W'((1 << ID_BITS) - 1);
      sleep_delta[pos] = DELTA_W'(want - sum);
      if (pos + 1 <= sleep_count) begin
        sleep_delta[pos+1] = sleep_delta[pos+1] - sleep_delta[pos];
      end
      sleep_count++;
      push_rsp(KIND_ACCEPT, '0, 1'b1);
    end
  endfunction

  function automatic void predict_tick();
    int unsigned woken;
    int unsigned i;
    if (sleep_count == 0) begin
      push_rsp(KIND_IDLE, '0, 1'b1);
    end else begin
      if (sleep_delta[0] != '0) begin
        sleep_delta[0] = sleep_delta[0] - 1'b1;
      end
      woken = 0;
      while (woken < sleep_count && sleep_delta[woken] == '0) begin
        woken++;
      end
      if (woken == 0) begin
        push_rsp(KIND_IDLE, '0, 1'b1);
      end else begin
        for (i = 0; i < woken; i++) begin
          push_rsp(KIND_WOKEN, sleep_pid[i], i == woken - 1);
        end
        for (i = 0; i + woken < sleep_count; i++) begin
          sleep_pid[i]   = sleep_pid[i+woken];
          sleep_delta[i] = sleep_delta[i+woken];
        end
        sleep_count = sleep_count - woken;
      end
    end
  endfunction

  task automatic send_request(input logic op, input logic [PID_W-1:0] pid,
                              input logic [DELTA_W-1:0] dly);
    while (!quiet && $urandom_range(99) < 33) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.func        <= op;
    req_if.process_id  <= pid;
    req_if.delay_ticks <= dly;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (op == 1'b0) begin
      predict_insert(pid, dly);
    end else begin
      predict_tick();
    end
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_response();
    wake_rsp_t want_rsp;
    if (pending_rsp.size() == 0) begin
      $error("unexpected result: kind %0d woken_id %0d last %0d",
             rsp_if.kind, rsp_if.woken_id, rsp_if.last);
      error_count++;
    end else begin
      want_rsp = pending_rsp.pop_front();
      if (rsp_if.kind !== want_rsp.kind) begin
        $error("kind: expected %0d, actual %0d", want_rsp.kind, rsp_if.kind);
        error_count++;
      end
      if (rsp_if.woken_id !== want_rsp.woken_id) begin
        $error("woken_id: expected %0d, actual %0d", want_rsp.woken_id, rsp_if.woken_id);
        error_count++;
      end
      if (rsp_if.last !== want_rsp.last) begin
        $error("last: expected %0d, actual %0d", want_rsp.last, rsp_if.last);
        error_count++;
      end
    end
  endtask

  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    rsp_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        check_response();
      end
      if (stall_request != 0) begin
        stall_left    = stall_request;
        stall_request = 0;
      end
      if (stall_left != 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= quiet || ($urandom_range(99) >= 33);
      end
    end
  end

  task automatic test_empty_tick();
    send_request(1'b1, 8'hFF, 32'hFFFF_FFFF);
    wait_drained();
  endtask

  // Sixteen sleepers that all end up with a total of one tick, alternating a
  // zero delay and a delay of one, so equal totals stack in arrival order.
  task automatic test_full_queue();
    int unsigned i;
    for (i = 0; i < QUEUE_DEPTH; i++) begin
      if (i == 0) begin
        send_request(1'b0, 8'h00, 32'h0);
      end else if (i == QUEUE_DEPTH - 1) begin
        send_request(1'b0, 8'hFF, 32'h1);
      end else begin
        send_request(1'b0, PID_W'(i * 17), DELTA_W'(i % 2));
      end
    end
    send_request(1'b0, 8'h3C, 32'h5);
    send_request(1'b1, 8'h00, 32'h0);
    wait_drained();
  endtask

  task automatic test_extreme_delay();
    send_request(1'b0, 8'hFF, 32'hFFFF_FFFF);
    send_request(1'b0, 8'hA5, 32'h2);
    send_request(1'b1, 8'h00, 32'h0);
    send_request(1'b1, 8'h00, 32'h0);
    wait_drained();
  endtask

  task automatic test_pause_until_drained();
    int unsigned round;
    int unsigned k;
    for (round = 0; round < 3; round++) begin
      for (k = 0; k < 3; k++) begin
        send_request(1'b0, PID_W'($urandom_range(0, 255)), DELTA_W'($urandom_range(0, 3)));
      end
      send_request(1'b1, PID_W'($urandom_range(0, 255)), $urandom());
      send_request(1'b1, PID_W'($urandom_range(0, 255)), $urandom());
      wait_drained();
    end
  endtask

  task automatic test_output_backpressure();
    int unsigned k;
    quiet         = 1'b1;
    stall_request = STALL_CYCLES;
    for (k = 0; k < 30; k++) begin
      if (k % 3 == 2) begin
        send_request(1'b1, PID_W'($urandom_range(0, 255)), $urandom());
      end else begin
        send_request(1'b0, PID_W'($urandom_range(0, 255)), DELTA_W'($urandom_range(0, 4)));
      end
    end
    quiet = 1'b0;
    wait_drained();
  endtask

  // Bursts of inserts fill the queue up to the full case, bursts of ticks
  // drain it again; a stretch in the middle runs without any idling.
  task automatic test_random_traffic(input int unsigned items);
    int unsigned sent;
    int unsigned burst;
    int unsigned k;
    logic        op;
    sent = 0;
    while (sent < items) begin
      quiet = (sent >= items / 2) && (sent < items / 2 + 80);
      burst = $urandom_range(1, 8);
      op    = 1'($urandom_range(0, 1));
      for (k = 0; k < burst && sent < items; k++) begin
        if (sent == items / 3 || sent == (2 * items) / 3) begin
          send_request(1'b0, PID_W'($urandom_range(0, 255)), {1'b1, 31'($urandom())});
        end else if (op == 1'b0) begin
          send_request(1'b0, PID_W'($urandom_range(0, 255)), DELTA_W'($urandom_range(0, 24)));
        end else begin
          send_request(1'b1, PID_W'($urandom_range(0, 255)), $urandom());
        end
        sent++;
      end
    end
    quiet = 1'b0;
    wait_drained();
  endtask

  initial begin
    req_if.valid       = 1'b0;
    req_if.func        = 1'b0;
    req_if.process_id  = '0;
    req_if.delay_ticks = '0;
    quiet              = 1'b0;
    stall_request      = 0;
    error_count        = 0;
    sleep_count        = 0;
    rst_ni             = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_tick();
    test_full_queue();
    test_extreme_delay();
    test_pause_until_drained();
    test_output_backpressure();
    test_random_traffic(412);

    wait_drained();
    repeat (QUEUE_DEPTH + 8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
